>>> hw/rtl/rtctc_pkg.sv
package rtctc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_READ_FAIL  = 2'd1,
    ST_BAD_SET    = 2'd2,
    ST_WRITE_FAIL = 2'd3
  } status_t;

  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;
  localparam logic [3:0] MAX_STEP   = 4'd10;
  localparam logic signed [19:0] DAY_SECS = 20'sd86400;

  // one input word
  typedef struct packed {
    logic       func;
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic       read_ok;
    logic       second_passed;
    logic [7:0] new_hour;
    logic [7:0] new_minute;
    logic [7:0] new_second;
    logic       write_ok;
  } item_t;

  // one result word
  typedef struct packed {
    status_t    status;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [5:0] bcd_hour;
    logic [6:0] bcd_minute;
    logic [6:0] bcd_second;
  } result_t;

  // tracker state
  typedef struct packed {
    logic [4:0] cached_hour;
    logic [5:0] cached_minute;
    logic [5:0] cached_second;
    logic [5:0] prev_hw_hour;
    logic [6:0] prev_hw_minute;
    logic [6:0] prev_hw_second;
    logic       prev_hw_valid;
    logic       manually_set;
  } state_t;

  // bcd byte (already masked to seven bits) to binary, nibbles unchecked
  function automatic logic [6:0] decode_bcd(input logic [6:0] v);
    decode_bcd = {3'b000, v[3:0]} + 7'(v[6:4]) * 7'd10;
  endfunction

  // binary value below 60 to bcd
  function automatic logic [6:0] encode_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - 6'(tens) * 6'd10;
    encode_bcd = {tens, ones[3:0]};
  endfunction

  // seconds of day for a decoded sample
  function automatic logic [17:0] day_secs(input logic [5:0] h, input logic [6:0] m,
                                          input logic [6:0] s);
    day_secs = 18'(h) * 18'd3600 + 18'(m) * 18'd60 + 18'(s);
  endfunction

endpackage

>>> hw/rtl/rtctc_calc.sv
module rtctc_calc (
  input  rtctc_pkg::item_t   item,
  input  rtctc_pkg::state_t  state,
  output rtctc_pkg::result_t res,
  output rtctc_pkg::state_t  state_next
);

  logic [5:0] dh;
  logic [6:0] dm;
  logic [6:0] ds;
  logic signed [19:0] diff;
  logic signed [19:0] diff_adj;
  logic [3:0] step;
  logic [6:0] sec_sum;
  logic [5:0] adv_sec;
  logic [5:0] adv_min;
  logic [4:0] adv_hour;
  logic [6:0] min_inc;
  logic [4:0] hour_inc;
  logic set_valid;
  logic sample;
  logic [6:0] enc_h;
  logic [6:0] enc_m;
  logic [6:0] enc_s;

  function automatic logic [5:0] decode_bcd6(input logic [5:0] v);
    logic [6:0] full;
    full = rtctc_pkg::decode_bcd({1'b0, v});
    decode_bcd6 = full[5:0];
  endfunction

  // decode the masked sample bytes
  assign dh = decode_bcd6(item.raw_hour[5:0]);
  assign dm = rtctc_pkg::decode_bcd(item.raw_minute[6:0]);
  assign ds = rtctc_pkg::decode_bcd(item.raw_second[6:0]);

  // elapsed seconds since previous sample, wrapped over a day
  assign diff = $signed({2'b00, rtctc_pkg::day_secs(dh, dm, ds)})
              - $signed({2'b00, rtctc_pkg::day_secs(state.prev_hw_hour,
                                                    state.prev_hw_minute,
                                                    state.prev_hw_second)});
  assign diff_adj = (diff < 0) ? diff + rtctc_pkg::DAY_SECS : diff;

  always_comb begin
    if (!state.prev_hw_valid || diff_adj < 0 ||
        diff_adj > $signed({16'd0, rtctc_pkg::MAX_STEP})) begin
      step = 4'd1;
    end else begin
      step = diff_adj[3:0];
    end
  end

  // advance the cached time with carries
  assign sec_sum  = {1'b0, state.cached_second} + 7'(step);
  assign min_inc  = {1'b0, state.cached_minute} + 7'd1;
  assign hour_inc = state.cached_hour + 5'd1;

  always_comb begin
    adv_sec  = state.cached_second;
    adv_min  = state.cached_minute;
    adv_hour = state.cached_hour;
    if (sec_sum >= 7'd60) begin
      adv_sec = 6'(sec_sum - 7'd60);
      if (min_inc >= 7'd60) begin
        adv_min  = 6'd0;
        adv_hour = (hour_inc >= 5'd24) ? 5'd0 : hour_inc;
      end else begin
        adv_min = min_inc[5:0];
      end
    end else begin
      adv_sec = sec_sum[5:0];
    end
  end

  // set value check and encodings
  assign set_valid = (item.new_second < rtctc_pkg::MIN_LIMIT)
                  && (item.new_minute < rtctc_pkg::MIN_LIMIT)
                  && (item.new_hour < rtctc_pkg::HOUR_LIMIT);
  assign enc_h = rtctc_pkg::encode_bcd(item.new_hour[5:0]);
  assign enc_m = rtctc_pkg::encode_bcd(item.new_minute[5:0]);
  assign enc_s = rtctc_pkg::encode_bcd(item.new_second[5:0]);

  assign sample = item.second_passed && item.read_ok;

  // result word and next state
  always_comb begin
    res        = '0;
    res.status = rtctc_pkg::ST_OK;
    state_next = state;
    if (item.func == rtctc_pkg::FUNC_SET) begin
      if (!set_valid) begin
        res.status = rtctc_pkg::ST_BAD_SET;
      end else begin
        res.bcd_hour   = enc_h[5:0];
        res.bcd_minute = enc_m;
        res.bcd_second = enc_s;
        if (!item.write_ok) begin
          res.status = rtctc_pkg::ST_WRITE_FAIL;
        end else begin
          res.hour                 = item.new_hour[5:0];
          res.minute               = item.new_minute[6:0];
          res.second               = item.new_second[6:0];
          state_next.cached_hour   = item.new_hour[4:0];
          state_next.cached_minute = item.new_minute[5:0];
          state_next.cached_second = item.new_second[5:0];
          state_next.manually_set  = 1'b1;
        end
      end
    end else if (state.manually_set) begin
      if (sample) begin
        state_next.cached_hour    = adv_hour;
        state_next.cached_minute  = adv_min;
        state_next.cached_second  = adv_sec;
        state_next.prev_hw_hour   = dh;
        state_next.prev_hw_minute = dm;
        state_next.prev_hw_second = ds;
        state_next.prev_hw_valid  = 1'b1;
        res.hour   = {1'b0, adv_hour};
        res.minute = {1'b0, adv_min};
        res.second = {1'b0, adv_sec};
      end else begin
        res.hour   = {1'b0, state.cached_hour};
        res.minute = {1'b0, state.cached_minute};
        res.second = {1'b0, state.cached_second};
      end
    end else if (item.read_ok) begin
      res.hour   = dh;
      res.minute = dm;
      res.second = ds;
    end else begin
      res.status = rtctc_pkg::ST_READ_FAIL;
    end
  end

endmodule

>>> hw/rtl/rtc_time_cache_tracker.sv
// Time-of-day tracker for an external BCD clock chip. Each accepted word gives
// exactly one result word, which moves from the input register into the
// result register as soon as the result register is free, and a new word
// can be taken every cycle in which in_stall is low:
// one input register, one pass of decode, elapsed-time and carry logic, and
// one result register. The cached time and last hardware sample update as a
// word leaves the input register, so the next word always sees the state left
// by the one before it.
module rtc_time_cache_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] raw_second,
  input  logic [7:0] raw_minute,
  input  logic [7:0] raw_hour,
  input  logic       read_ok,
  input  logic       second_passed,
  input  logic [7:0] new_hour,
  input  logic [7:0] new_minute,
  input  logic [7:0] new_second,
  input  logic       write_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [5:0] hour,
  output logic [6:0] minute,
  output logic [6:0] second,
  output logic [5:0] bcd_hour_out,
  output logic [6:0] bcd_minute_out,
  output logic [6:0] bcd_second_out
);

  rtctc_pkg::item_t   item_q;
  logic               item_valid;
  rtctc_pkg::state_t  state;
  rtctc_pkg::state_t  state_next;
  rtctc_pkg::result_t res;
  rtctc_pkg::result_t res_q;
  logic               out_free;
  logic               fire;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= '{func, raw_second, raw_minute, raw_hour, read_ok, second_passed,
                  new_hour, new_minute, new_second, write_ok};
    end
  end

  rtctc_calc u_calc (
    .item       (item_q),
    .state      (state),
    .res        (res),
    .state_next (state_next)
  );

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign status         = res_q.status;
  assign hour           = res_q.hour;
  assign minute         = res_q.minute;
  assign second         = res_q.second;
  assign bcd_hour_out   = res_q.bcd_hour;
  assign bcd_minute_out = res_q.bcd_minute;
  assign bcd_second_out = res_q.bcd_second;

endmodule

>>> hw/rtl/rtctc_checker.sv
module rtctc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [5:0] hour,
  input logic [6:0] minute,
  input logic [6:0] second,
  input logic [5:0] bcd_hour_out,
  input logic [6:0] bcd_minute_out,
  input logic [6:0] bcd_second_out
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(hour)
      && $stable(minute) && $stable(second) && $stable(bcd_hour_out))
    else $error("stalled result word changed");

  // failed read reports zero time and no encodings
  a_read_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rtctc_pkg::ST_READ_FAIL |->
      hour == 6'd0 && minute == 7'd0 && second == 7'd0 && bcd_hour_out == 6'd0)
    else $error("read failure with nonzero fields");

  // rejected set reports all zero
  a_bad_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rtctc_pkg::ST_BAD_SET |->
      hour == 6'd0 && minute == 7'd0 && second == 7'd0 && bcd_hour_out == 6'd0
      && bcd_minute_out == 7'd0 && bcd_second_out == 7'd0)
    else $error("invalid set with nonzero fields");

  // failed write keeps time zero and gives legal encodings
  a_write_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rtctc_pkg::ST_WRITE_FAIL |->
      hour == 6'd0 && minute == 7'd0 && second == 7'd0
      && bcd_minute_out[3:0] <= 4'd9 && bcd_second_out[3:0] <= 4'd9)
    else $error("write failure with bad fields");

endmodule

bind rtc_time_cache_tracker rtctc_checker u_rtctc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .hour           (hour),
  .minute         (minute),
  .second         (second),
  .bcd_hour_out   (bcd_hour_out),
  .bcd_minute_out (bcd_minute_out),
  .bcd_second_out (bcd_second_out)
);
